### hw/rtl/lsh_pkg.sv
// Package for the Laplacian sharpen stream block.
// Holds default sizes, field widths, register reset values and the register index codes.
// No dependencies.
package lsh_pkg;

    // Default size limits handed to the top-level parameters.
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int DEF_MAX_CHANNELS = 3;

    // Widths of the stream fields.
    localparam int PIX_W      = 8;
    localparam int ROW_OUT_W  = 12;
    localparam int BYTE_OUT_W = 13;

    // Widths and reset values of the configuration registers.
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CHAN_REG_W   = 2;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CHAN_REG_W-1:0]   CHAN_RESET   = 2'd1;

    // Configuration bus sizing.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Filter arithmetic: gain on the center tap and width of the signed sum.
    localparam int CENTER_GAIN = 5;
    localparam int SUM_W       = 12;

    // Register index codes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_WIDTH    = 2'd0,
        REG_HEIGHT   = 2'd1,
        REG_CHANNELS = 2'd2
    } t_reg_idx;

    // Clamp a two's complement filter sum into the 0..255 pixel range.
    function automatic logic [PIX_W-1:0] clamp_pixel(input logic [SUM_W-1:0] sum);
        logic [PIX_W-1:0] res;
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (sum > SUM_W'(255)) begin
            res = '1;
        end else begin
            res = sum[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/lsh_ram.sv
// Generic simple RAM: one write port and two read ports with registered read data.
// A read of the address being written returns the old contents. No dependencies.
module lsh_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 6144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [DATA_W-1:0]        o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DATA_W-1:0]        o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hw/rtl/laplacian_sharpen_3x3_stream.sv
// Top level of the five-point Laplacian sharpen over a raster byte stream.
// Depends on lsh_pkg and on lsh_ram for the two line stores.
//
// Usage:
// Image bytes enter on the input channel (i_valid, o_ready, i_sample) in raster
// order with channels interleaved. Sharpened bytes leave on the output channel
// (o_valid, i_ready) with their row and byte index, a run_last flag and a
// frame_end flag. Row r-1 is produced while input row r arrives; the first input
// row yields nothing and each byte of the last row yields two results, the
// second one being the zero byte of the bottom border row.
// Each byte passes the line stores and the second-stage register, and its result
// is presented from the output register.
// Throughput: one byte per cycle on middle rows while the receiver is ready, set
// by the single read of each line store per byte; on the last row a byte waits
// for both results of the byte before; the output register sends one per cycle.
// The line stores are two RAMs that swap roles at each row end; the RAM being
// refilled is read and written at the same address in one cycle.
// Reset clears the counters, empties the pipeline and loads the register
// defaults (640 x 480, one channel). Line store contents are not cleared.
// When the receiver stalls, the output register holds its result and the input
// side keeps taking bytes until the stage behind the RAMs is also full.
// A register write restarts the frame; write registers only while idle.
module laplacian_sharpen_3x3_stream #(
    parameter int MAX_WIDTH    = lsh_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = lsh_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = lsh_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [lsh_pkg::PIX_W-1:0]       i_sample,
    // Output stream.
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lsh_pkg::PIX_W-1:0]       o_sharp_value,
    output logic [lsh_pkg::ROW_OUT_W-1:0]   o_out_row,
    output logic [lsh_pkg::BYTE_OUT_W-1:0]  o_out_byte,
    output logic                            o_run_last,
    output logic                            o_frame_end,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsh_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lsh_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lsh_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import lsh_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW   = $clog2(LINE_DEPTH);
    localparam int BW   = $clog2(LINE_DEPTH + 1);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RCW  = $clog2(MAX_HEIGHT);
    localparam int CHW  = $clog2(MAX_CHANNELS + 1);
    localparam int LIW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  r_image_width;
    logic [HEIGHT_REG_W-1:0] r_image_height;
    logic [CHAN_REG_W-1:0]   r_channel_count;
    logic                    cfg_we;
    t_reg_idx                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= WIDTH_RESET;
            r_image_height  <= HEIGHT_RESET;
            r_channel_count <= CHAN_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_WIDTH:    r_image_width   <= pwdata[WIDTH_REG_W-1:0];
                REG_HEIGHT:   r_image_height  <= pwdata[HEIGHT_REG_W-1:0];
                REG_CHANNELS: r_channel_count <= pwdata[CHAN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_WIDTH:    prdata = APB_DATA_W'(r_image_width);
            REG_HEIGHT:   prdata = APB_DATA_W'(r_image_height);
            REG_CHANNELS: prdata = APB_DATA_W'(r_channel_count);
            default:      prdata = '0;
        endcase
    end

    // A write to a known register restarts the frame.
    logic cfg_restart;
    assign cfg_restart = cfg_we && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT ||
                                    cfg_idx == REG_CHANNELS);

    // Effective geometry, with the registers saturated into their legal ranges.
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [CHW-1:0] ch_eff;
    logic [BW-1:0]  row_bytes;

    always_comb begin
        if (r_image_width < 3) begin
            w_eff = WW'(3);
        end else if (r_image_width > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        if (r_image_height < 3) begin
            h_eff = HW'(3);
        end else if (r_image_height > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_image_height);
        end
        if (r_channel_count < 1) begin
            ch_eff = CHW'(1);
        end else if (r_channel_count > MAX_CHANNELS) begin
            ch_eff = CHW'(MAX_CHANNELS);
        end else begin
            ch_eff = CHW'(r_channel_count);
        end
    end

    assign row_bytes = BW'(w_eff) * BW'(ch_eff);

    // ------------------------------------------------------------------
    // Input stage: position counters and line store addressing
    // ------------------------------------------------------------------
    logic           in_xfer;
    logic [RCW-1:0] r_row;
    logic [BW-1:0]  r_byte;
    logic           r_bank_sel;
    logic [RCW-1:0] n_row;
    logic [BW-1:0]  n_byte;
    logic           n_bank_sel;
    logic           last_row;
    logic           last_byte;
    logic [BW:0]    right_pos;
    logic           interior;
    logic [AW-1:0]  addr_center;
    logic [AW-1:0]  addr_right;

    assign last_row    = (HW'(r_row) + 1'b1) >= h_eff;
    assign last_byte   = (r_byte + 1'b1) >= row_bytes;
    assign right_pos   = {1'b0, r_byte} + (BW + 1)'(ch_eff);
    assign interior    = (r_row >= RCW'(2)) && (r_byte >= BW'(ch_eff)) &&
                         (right_pos < (BW + 1)'(row_bytes));
    assign addr_center = r_byte[AW-1:0];
    assign addr_right  = right_pos[AW-1:0];

    // Counter advance on each input transfer; rows wrap at the frame end.
    always_comb begin
        n_row      = r_row;
        n_byte     = r_byte + 1'b1;
        n_bank_sel = r_bank_sel;
        if (last_byte) begin
            n_byte     = '0;
            n_bank_sel = !r_bank_sel;
            n_row      = last_row ? '0 : RCW'(r_row + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_row      <= '0;
            r_byte     <= '0;
            r_bank_sel <= 1'b0;
        end else if (in_xfer) begin
            r_row      <= n_row;
            r_byte     <= n_byte;
            r_bank_sel <= n_bank_sel;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The bank selected by r_bank_sel takes the incoming row and
    // gives the row two above at the same address; the other bank holds the
    // row above and is read at the center and right positions.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] ram0_qa;
    logic [PIX_W-1:0] ram0_qb;
    logic [PIX_W-1:0] ram1_qa;
    logic [PIX_W-1:0] ram1_qb;

    lsh_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (LINE_DEPTH)
    ) u_line0 (
        .i_clk     (i_clk),
        .i_we      (in_xfer && !r_bank_sel),
        .i_waddr   (addr_center),
        .i_wdata   (i_sample),
        .i_re_a    (in_xfer),
        .i_raddr_a (addr_center),
        .o_rdata_a (ram0_qa),
        .i_re_b    (in_xfer),
        .i_raddr_b (addr_right),
        .o_rdata_b (ram0_qb)
    );

    lsh_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (LINE_DEPTH)
    ) u_line1 (
        .i_clk     (i_clk),
        .i_we      (in_xfer && r_bank_sel),
        .i_waddr   (addr_center),
        .i_wdata   (i_sample),
        .i_re_a    (in_xfer),
        .i_raddr_a (addr_center),
        .o_rdata_a (ram1_qa),
        .i_re_b    (in_xfer),
        .i_raddr_b (addr_right),
        .o_rdata_b (ram1_qb)
    );

    // ------------------------------------------------------------------
    // Second stage: one item whose line store data is now available
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    logic             r_s1_phase;
    logic             r_s1_has_out;
    logic             r_s1_last_row;
    logic             r_s1_last_byte;
    logic             r_s1_interior;
    logic             r_s1_bank_sel;
    logic [RCW-1:0]   r_s1_row;
    logic [BW-1:0]    r_s1_byte;
    logic [PIX_W-1:0] r_s1_sample;

    logic             out_free;
    logic             emit;
    logic             s1_done;

    assign out_free = !o_valid || i_ready;
    assign emit     = r_s1_valid && r_s1_has_out && out_free;
    assign s1_done  = r_s1_valid &&
                      (!r_s1_has_out || (emit && (r_s1_phase || !r_s1_last_row)));
    assign o_ready  = !r_s1_valid || s1_done;
    assign in_xfer  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
            r_s1_phase <= 1'b0;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (emit) begin
            // First of two results sent; the bottom border byte follows.
            r_s1_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_has_out   <= (r_row != '0);
            r_s1_last_row  <= last_row;
            r_s1_last_byte <= last_byte;
            r_s1_interior  <= interior;
            r_s1_bank_sel  <= r_bank_sel;
            r_s1_row       <= r_row;
            r_s1_byte      <= r_byte;
            r_s1_sample    <= i_sample;
        end
    end

    // Neighbor taps from the two banks.
    logic [PIX_W-1:0] tap_center;
    logic [PIX_W-1:0] tap_right;
    logic [PIX_W-1:0] tap_up;
    logic [PIX_W-1:0] tap_left;

    assign tap_center = r_s1_bank_sel ? ram0_qa : ram1_qa;
    assign tap_right  = r_s1_bank_sel ? ram0_qb : ram1_qb;
    assign tap_up     = r_s1_bank_sel ? ram1_qa : ram0_qa;

    // The left tap is the center byte of the item one pixel back.
    logic [PIX_W-1:0] r_left [MAX_CHANNELS];
    logic [CHW-1:0]   ch_m1;

    assign ch_m1    = ch_eff - 1'b1;
    assign tap_left = r_left[ch_m1[LIW-1:0]];

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_left[0] <= tap_center;
            for (int k = 1; k < MAX_CHANNELS; k++) begin
                r_left[k] <= r_left[k-1];
            end
        end
    end

    // Five-point Laplacian sum, modulo 2**SUM_W, then clamped.
    logic [SUM_W-1:0] lap_sum;
    logic [PIX_W-1:0] sharp;

    assign lap_sum = SUM_W'(tap_center) * SUM_W'(CENTER_GAIN) - SUM_W'(tap_left)
                     - SUM_W'(tap_right) - SUM_W'(tap_up) - SUM_W'(r_s1_sample);
    assign sharp   = r_s1_interior ? clamp_pixel(lap_sum) : '0;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_out_byte <= BYTE_OUT_W'(r_s1_byte);
            if (!r_s1_phase) begin
                // Filtered byte of the row above.
                o_sharp_value <= sharp;
                o_out_row     <= ROW_OUT_W'(RCW'(r_s1_row - 1'b1));
                o_run_last    <= !r_s1_last_row;
                o_frame_end   <= 1'b0;
            end else begin
                // Zero byte of the bottom border row.
                o_sharp_value <= '0;
                o_out_row     <= ROW_OUT_W'(r_s1_row);
                o_run_last    <= 1'b1;
                o_frame_end   <= r_s1_last_byte;
            end
        end
    end

    assign o_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_phase_only_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_phase |-> (r_s1_valid && r_s1_last_row))
        else $error("second result pending outside the last row");

    a_frame_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> (o_run_last && o_sharp_value == '0))
        else $error("frame end marked on a non-border result");

    a_byte_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte < row_bytes)
        else $error("byte counter past the row length");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HW'(r_row) < h_eff)
        else $error("row counter past the frame height");

endmodule

### tb/testbench.sv
// Self-checking testbench for the five-point Laplacian sharpen stream block.
// Needs lsh_pkg and the RTL of laplacian_sharpen_3x3_stream; a built-in predictor
// works out the expected results for every input transfer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lsh_pkg::*;

    localparam int LINE_BYTES   = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 850;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [PIX_W-1:0]      value;
        logic [ROW_OUT_W-1:0]  row;
        logic [BYTE_OUT_W-1:0] pos;
        logic                  run_last;
        logic                  frame_end;
    } t_sharp_result;

    typedef struct {
        logic [PIX_W-1:0] value;
        bit               drain;
    } t_pending_byte;

    // Clock, reset and block ports.
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_sample = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PIX_W-1:0]      o_sharp_value;
    logic [ROW_OUT_W-1:0]  o_out_row;
    logic [BYTE_OUT_W-1:0] o_out_byte;
    logic                  o_run_last;
    logic                  o_frame_end;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    laplacian_sharpen_3x3_stream dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sharp_value (o_sharp_value),
        .o_out_row     (o_out_row),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_frame_end   (o_frame_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: raw register values, two line banks and the raster position.
    int unsigned      cfg_width  = WIDTH_RESET;
    int unsigned      cfg_height = HEIGHT_RESET;
    int unsigned      cfg_chan   = CHAN_RESET;
    logic [PIX_W-1:0] line_bank [2][LINE_BYTES];
    int unsigned      row_idx    = 0;
    int unsigned      col_idx    = 0;
    bit               fill_bank  = 1'b0;

    t_sharp_result    sharp_expected [$];
    t_pending_byte    pending_bytes [$];
    int unsigned      bytes_queued    = 0;
    int unsigned      bytes_accepted  = 0;
    int unsigned      fail_count      = 0;
    int unsigned      holds_requested = 0;

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Works out the results of one input byte and advances the raster position.
    function automatic void sharpen_byte(input logic [PIX_W-1:0] s);
        int unsigned   w;
        int unsigned   h;
        int unsigned   ch;
        int unsigned   row_bytes;
        int            acc;
        bit            last_row;
        bit            last_col;
        t_sharp_result res;
        w         = clamp_cfg(cfg_width, 3, DEF_MAX_WIDTH);
        h         = clamp_cfg(cfg_height, 3, DEF_MAX_HEIGHT);
        ch        = clamp_cfg(cfg_chan, 1, DEF_MAX_CHANNELS);
        row_bytes = w * ch;
        last_row  = (row_idx + 1 >= h);
        last_col  = (col_idx + 1 >= row_bytes);
        if (row_idx >= 1) begin
            res = '0;
            // Interior bytes: the bank being filled still holds the row above the center.
            if (row_idx >= 2 && col_idx >= ch && col_idx + ch < row_bytes) begin
                acc = CENTER_GAIN * int'(line_bank[!fill_bank][col_idx])
                    - int'(line_bank[!fill_bank][col_idx - ch])
                    - int'(line_bank[!fill_bank][col_idx + ch])
                    - int'(line_bank[fill_bank][col_idx])
                    - int'(s);
                res.value = (acc < 0) ? 8'd0 : ((acc > 255) ? 8'd255 : PIX_W'(acc));
            end
            res.row       = ROW_OUT_W'(row_idx - 1);
            res.pos       = BYTE_OUT_W'(col_idx);
            res.run_last  = !last_row;
            res.frame_end = 1'b0;
            sharp_expected.push_back(res);
            // The last input row also yields the zero bottom border row.
            if (last_row) begin
                res           = '0;
                res.row       = ROW_OUT_W'(row_idx);
                res.pos       = BYTE_OUT_W'(col_idx);
                res.run_last  = 1'b1;
                res.frame_end = last_col;
                sharp_expected.push_back(res);
            end
        end
        line_bank[fill_bank][col_idx] = s;
        if (last_col) begin
            col_idx   = 0;
            fill_bank = !fill_bank;
            row_idx   = last_row ? 0 : row_idx + 1;
        end else begin
            col_idx++;
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                sharpen_byte(i_sample);
                bytes_accepted++;
            end
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].drain && sharp_expected.size() != 0)) begin
                i_sample <= pending_bytes[0].value;
                i_valid  <= 1'b1;
                pending_bytes.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 16);
                    gap_left   = $urandom_range(0, 5);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each output transfer and stalls on a pattern of its own.
    t_sharp_result got;
    t_sharp_result want;
    logic [15:0]   ready_pattern = '1;
    logic [7:0]    pattern_pos   = '0;
    int unsigned   hold_left     = 0;
    int unsigned   holds_started = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_sharp_value, o_out_row, o_out_byte, o_run_last, o_frame_end};
            if (sharp_expected.size() == 0) begin
                note_failure($sformatf({"unexpected result: value %0d row %0d byte %0d ",
                    "last %0b end %0b"},
                    got.value, got.row, got.pos, got.run_last, got.frame_end));
            end else begin
                want = sharp_expected.pop_front();
                if (got !== want) begin
                    note_failure($sformatf({"result mismatch: expected value %0d row %0d byte %0d ",
                        "last %0b end %0b, got value %0d row %0d byte %0d last %0b end %0b"},
                        want.value, want.row, want.pos, want.run_last, want.frame_end,
                        got.value, got.row, got.pos, got.run_last, got.frame_end));
                end
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (holds_started != holds_requested && o_valid) begin
            // Long hold-off so that the block fills and stalls its input.
            hold_left = LONG_HOLD;
            holds_started++;
            i_ready <= 1'b0;
        end else begin
            pattern_pos++;
            if (pattern_pos == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom) | 16'h0001;
                    default: ready_pattern = 16'($urandom | $urandom) | 16'h8000;
                endcase
            end
            i_ready <= ready_pattern[pattern_pos[3:0]];
        end
    end

    // Register write followed by a read back of the same register.
    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] readback;
        case (idx)
            REG_WIDTH:  mask = (1 << WIDTH_REG_W) - 1;
            REG_HEIGHT: mask = (1 << HEIGHT_REG_W) - 1;
            default:    mask = (1 << CHAN_REG_W) - 1;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value & mask;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // The write restarts the frame; line contents stay.
        case (idx)
            REG_WIDTH:  cfg_width = value & mask;
            REG_HEIGHT: cfg_height = value & mask;
            default:    cfg_chan = value & mask;
        endcase
        row_idx   = 0;
        col_idx   = 0;
        fill_bank = 1'b0;
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((readback & mask) !== (value & mask)) begin
            note_failure($sformatf("register %s read back %0d, expected %0d",
                         idx.name(), readback & mask, value & mask));
        end
    endtask

    task automatic load_geometry(input int unsigned w, input int unsigned h,
                                 input int unsigned ch);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_CHANNELS, ch);
    endtask

    task automatic queue_byte(input logic [PIX_W-1:0] value, input bit drain);
        t_pending_byte item;
        item.value = value;
        item.drain = drain;
        pending_bytes.push_back(item);
        bytes_queued++;
    endtask

    // Random bytes; the one at drain_at waits until every result has come.
    task automatic queue_bytes(input int unsigned count, input int drain_at);
        for (int i = 0; i < count; i++) begin
            queue_byte(8'($urandom), i == drain_at);
        end
    endtask

    // Waits until every byte went through and every result came, then lets the
    // pipeline empty out.
    task automatic settle();
        do begin
            @(posedge i_clk);
        end while (bytes_accepted != bytes_queued || sharp_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int unsigned frame_size(input int unsigned w, input int unsigned h,
                                               input int unsigned ch);
        return clamp_cfg(w, 3, DEF_MAX_WIDTH) * clamp_cfg(h, 3, DEF_MAX_HEIGHT)
             * clamp_cfg(ch, 1, DEF_MAX_CHANNELS);
    endfunction

    // Stimulus and final verdict.
    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned ch;
        int unsigned n;
        int unsigned fbytes;
        int unsigned random_count;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A few bytes at the reset geometry: still in the first row, so no results.
        for (int i = 0; i < 4; i++) begin
            queue_byte(8'($urandom), 1'b0);
        end
        settle();

        // Smallest image: a bright center that clamps high, then a dark one that clamps
        // low; the second frame follows the wrap to row zero.
        load_geometry(3, 3, 1);
        for (int i = 0; i < 9; i++) begin
            queue_byte((i == 4) ? 8'hFF : 8'h00, 1'b0);
        end
        for (int i = 0; i < 9; i++) begin
            queue_byte((i == 4) ? 8'h00 : 8'hFF, 1'b0);
        end
        settle();

        // Top part of the tallest image with saturated width and channel count.
        load_geometry(0, 8191, 0);
        holds_requested++;
        queue_bytes(300, 150);
        settle();

        // Start of the first row of the widest color image with the shortest height.
        load_geometry(4095, 3, 3);
        holds_requested++;
        queue_bytes(200, 100);
        settle();

        // Random small geometries, whole frames plus sometimes a cut-off frame.
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(11, 24);
                default: w = $urandom_range(3, 10);
            endcase
            h  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            ch = $urandom_range(0, 3);
            load_geometry(w, h, ch);
            fbytes = frame_size(w, h, ch);
            n = fbytes * ((fbytes > 150) ? 1 : $urandom_range(1, 3));
            if ($urandom_range(0, 1) == 1) begin
                n += $urandom_range(0, fbytes - 1);
            end
            queue_bytes(n, ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, n - 1)) : -1);
            random_count += n;
            settle();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog far above the slowest correct run.
    initial begin
        #(60_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
